// File: src/bitmap_page_allocator_core_defines.svh
// Assertion macros for the bitmap page allocator checker.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define BPA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/bpa_pkg.sv
// Types, codes and helpers shared by the bitmap page allocator.
package bpa_pkg;

	localparam int WORD_BITS = 64;
	localparam int WORD_SH   = 6;
	localparam int ADDR_W    = 48;
	localparam int CNT_W     = 13;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [KIND_W-1:0] KIND_ALLOC_PAGE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE_PAGE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ALLOC_RUN  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_FREE_RUN   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGES_IN_USE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED_PAGES = 2'd2;

	localparam logic [CNT_W-1:0] PAGES_IN_USE_RST = 13'd4096;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FPAGE,
		ST_FRANGE,
		ST_ALOAD,
		ST_AFREE,
		ST_AUSED,
		ST_MREAD,
		ST_MWRITE,
		ST_DONE
	} state_t;

	// Bits below n set, n in 0..64.
	function automatic logic [WORD_BITS-1:0] low_mask(input logic [WORD_SH:0] n);
		logic [WORD_BITS-1:0] m;
		begin
			if (n >= (WORD_SH+1)'(WORD_BITS)) begin
				m = '1;
			end else begin
				m = (WORD_BITS'(1) << n) - WORD_BITS'(1);
			end
			return m;
		end
	endfunction

endpackage

// File: src/bpa_ffs.sv
// Find-first-set over one bitmap word: the shared search unit.
module bpa_ffs (
	input  logic [bpa_pkg::WORD_BITS-1:0] vec,
	output logic                          found,
	output logic [bpa_pkg::WORD_SH-1:0]   pos
);

	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int i = bpa_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (vec[i]) begin
				found = 1'b1;
				pos   = bpa_pkg::WORD_SH'(i);
			end
		end
	end

endmodule

// File: src/bpa_bitmap_ram.sv
// Single-port-write, single-port-read bitmap memory with registered read data.
module bpa_bitmap_ram #(
	parameter int ROWS = 64,
	parameter int AW   = 6
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [bpa_pkg::WORD_BITS-1:0] wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [bpa_pkg::WORD_BITS-1:0] rdata
);

	logic [bpa_pkg::WORD_BITS-1:0] mem_q [ROWS];
	logic [bpa_pkg::WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/bitmap_page_allocator_core.sv
// Bitmap page allocator: first-fit page and run allocation over a 64-bit-word bitmap.
// Reset: config returns to defaults, then a clearing pass writes MAX_PAGES/64 words
// with s_axis_tready low; config writes are taken meanwhile. Allocation: each bitmap
// word is fetched and searched, switching between free and used search at each
// boundary met, then the run's words are marked. Free: each word touched is cleared.
// One request at a time: one read/modify/write port on the bitmap, one search unit.
module bitmap_page_allocator_core #(
	parameter int PAGE_BYTES = 4096,
	parameter int MAX_PAGES  = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [47:0] address, [60:48] page_total, [63:61] zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [47:0] result_address
	output logic        m_axis_tuser,  // [0] ok
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_wdata
);

	localparam int PSH  = $clog2(PAGE_BYTES);
	localparam int IW   = $clog2(MAX_PAGES) + 1;
	localparam int CW   = (IW > bpa_pkg::CNT_W) ? IW : bpa_pkg::CNT_W;
	localparam int XW   = CW - bpa_pkg::WORD_SH;
	localparam int ROWS = MAX_PAGES / bpa_pkg::WORD_BITS;
	localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int AW   = bpa_pkg::ADDR_W;
	localparam int PGW  = AW - PSH;
	localparam int WB   = bpa_pkg::WORD_BITS;
	localparam int WS   = bpa_pkg::WORD_SH;

	bpa_pkg::state_t state_q, state_d;

	logic [AW-1:0]                  base_q;
	logic [bpa_pkg::CNT_W-1:0]      pages_q;
	logic [bpa_pkg::CNT_W-1:0]      resv_q;
	logic [RAW-1:0]                 clr_q;
	logic                           ovalid_q;
	logic [AW-1:0]                  odata_q;
	logic                           ook_q;

	logic [AW-1:0]                  addr_q;
	logic [bpa_pkg::CNT_W-1:0]      need_q;
	logic                           below_q;
	logic [PGW-1:0]                 page_q;
	logic [CW-1:0]                  p_q;
	logic [CW-1:0]                  start_q;
	logic [CW-1:0]                  lo_q;
	logic [CW-1:0]                  hi_q;
	logic                           look_used_q;
	logic                           set_q;
	logic [WB-1:0]                  rmask_q;
	logic [WB-1:0]                  cmask_q;
	logic [WB-1:0]                  mmask_q;
	logic [AW-1:0]                  res_q;
	logic                           ok_q;

	logic [AW-1:0]                  in_addr;
	logic [bpa_pkg::CNT_W-1:0]      in_total;
	logic [bpa_pkg::KIND_W-1:0]     in_kind;
	logic                           in_free;
	logic                           accept;

	logic [CW-1:0]                  count_w;
	logic [CW-1:0]                  resv_w;
	logic [CW-1:0]                  need_w;
	logic [XW-1:0]                  wi;
	logic [CW-1:0]                  wbase;
	logic [CW-1:0]                  nb;
	logic [WB-1:0]                  pmask;
	logic [WB-1:0]                  eff;
	logic [WB-1:0]                  search_vec;
	logic                           ffs_found;
	logic [WS-1:0]                  ffs_pos;
	logic [CW-1:0]                  hit_g;
	logic                           run_hit_ok;
	logic                           run_end_ok;
	logic                           past_end;
	logic                           free_skip;
	logic [CW:0]                    free_sum;
	logic [CW-1:0]                  free_hi;
	logic                           out_load;

	logic                           ram_we;
	logic [RAW-1:0]                 ram_waddr;
	logic [WB-1:0]                  ram_wdata;
	logic                           ram_re;
	logic [WB-1:0]                  ram_rdata;

	// Number of bits of [b, b+64) that lie below x.
	function automatic logic [WS:0] span_clamp(input logic [CW-1:0] x, input logic [CW-1:0] b);
		logic [CW-1:0] d;
		logic [WS:0]   r;
		begin
			d = x - b;
			if (x <= b) begin
				r = '0;
			end else if (d >= CW'(WB)) begin
				r = (WS+1)'(WB);
			end else begin
				r = d[WS:0];
			end
			return r;
		end
	endfunction

	assign in_addr  = s_axis_tdata[AW-1:0];
	assign in_total = s_axis_tdata[AW+bpa_pkg::CNT_W-1:AW];
	assign in_kind  = s_axis_tuser;
	assign in_free  = (in_kind == bpa_pkg::KIND_FREE_PAGE) || (in_kind == bpa_pkg::KIND_FREE_RUN);
	assign accept   = s_axis_tvalid && s_axis_tready;

	assign count_w = (CW'(pages_q) >= CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(pages_q);
	assign resv_w  = CW'(resv_q);
	assign need_w  = CW'(need_q);

	assign wi    = p_q[CW-1:WS];
	assign wbase = {wi, WS'(0)};
	assign nb    = {wi + XW'(1), WS'(0)};
	assign pmask = ~bpa_pkg::low_mask({1'b0, p_q[WS-1:0]});
	assign eff   = ram_rdata | rmask_q | cmask_q;

	assign search_vec = ((state_q == bpa_pkg::ST_AUSED) ? eff : ~eff) & pmask;

	bpa_ffs u_ffs (
		.vec   (search_vec),
		.found (ffs_found),
		.pos   (ffs_pos)
	);

	assign hit_g      = {wi, ffs_pos};
	assign run_hit_ok = (hit_g - start_q) >= need_w;
	assign run_end_ok = (nb - start_q) >= need_w;
	assign past_end   = nb >= count_w;

	assign free_skip = below_q || (page_q >= PGW'(count_w)) || (need_q == '0);
	assign free_sum  = (CW+1)'(page_q[CW-1:0]) + (CW+1)'(need_q);
	assign free_hi   = (free_sum >= (CW+1)'(count_w)) ? count_w : free_sum[CW-1:0];

	assign out_load = (state_q == bpa_pkg::ST_DONE) && (!ovalid_q || m_axis_tready);

	bpa_bitmap_ram #(
		.ROWS (ROWS),
		.AW   (RAW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (p_q[RAW+WS-1:WS]),
		.rdata (ram_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bpa_pkg::ST_CLEAR: begin
				if (clr_q == RAW'(ROWS - 1)) state_d = bpa_pkg::ST_IDLE;
			end
			bpa_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (in_free) begin
						state_d = bpa_pkg::ST_FPAGE;
					end else if ((in_kind == bpa_pkg::KIND_ALLOC_RUN) && (in_total == '0)) begin
						state_d = bpa_pkg::ST_DONE;
					end else begin
						state_d = bpa_pkg::ST_ALOAD;
					end
				end
			end
			bpa_pkg::ST_FPAGE: begin
				state_d = bpa_pkg::ST_FRANGE;
			end
			bpa_pkg::ST_FRANGE: begin
				state_d = free_skip ? bpa_pkg::ST_DONE : bpa_pkg::ST_MREAD;
			end
			bpa_pkg::ST_ALOAD: begin
				state_d = look_used_q ? bpa_pkg::ST_AUSED : bpa_pkg::ST_AFREE;
			end
			bpa_pkg::ST_AFREE: begin
				if (ffs_found) state_d = bpa_pkg::ST_AUSED;
				else if (past_end) state_d = bpa_pkg::ST_DONE;
				else state_d = bpa_pkg::ST_ALOAD;
			end
			bpa_pkg::ST_AUSED: begin
				if (ffs_found) begin
					state_d = run_hit_ok ? bpa_pkg::ST_MREAD : bpa_pkg::ST_AFREE;
				end else if (run_end_ok) begin
					state_d = bpa_pkg::ST_MREAD;
				end else if (past_end) begin
					state_d = bpa_pkg::ST_DONE;
				end else begin
					state_d = bpa_pkg::ST_ALOAD;
				end
			end
			bpa_pkg::ST_MREAD: begin
				state_d = bpa_pkg::ST_MWRITE;
			end
			bpa_pkg::ST_MWRITE: begin
				state_d = (nb >= hi_q) ? bpa_pkg::ST_DONE : bpa_pkg::ST_MREAD;
			end
			bpa_pkg::ST_DONE: begin
				if (!ovalid_q || m_axis_tready) state_d = bpa_pkg::ST_IDLE;
			end
			default: state_d = bpa_pkg::ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		ram_waddr     = p_q[RAW+WS-1:WS];
		ram_wdata     = '0;
		case (state_q)
			bpa_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			bpa_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			bpa_pkg::ST_ALOAD,
			bpa_pkg::ST_MREAD: begin
				ram_re = 1'b1;
			end
			bpa_pkg::ST_MWRITE: begin
				ram_we    = 1'b1;
				ram_wdata = set_q ? (ram_rdata | mmask_q) : (ram_rdata & ~mmask_q);
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	// Control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bpa_pkg::ST_CLEAR;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
			base_q   <= '0;
			pages_q  <= bpa_pkg::PAGES_IN_USE_RST;
			resv_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bpa_pkg::ST_CLEAR) clr_q <= clr_q + RAW'(1);
			if (out_load) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					bpa_pkg::REG_BASE_ADDRESS:   base_q  <= cfg_wdata;
					bpa_pkg::REG_PAGES_IN_USE:   pages_q <= cfg_wdata[bpa_pkg::CNT_W-1:0];
					bpa_pkg::REG_RESERVED_PAGES: resv_q  <= cfg_wdata[bpa_pkg::CNT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Request payload and search state
	always_ff @(posedge clk) begin
		if (out_load) begin
			odata_q <= res_q;
			ook_q   <= ok_q;
		end
		case (state_q)
			bpa_pkg::ST_IDLE: begin
				if (accept) begin
					addr_q      <= in_addr;
					need_q      <= ((in_kind == bpa_pkg::KIND_ALLOC_RUN) ||
					                (in_kind == bpa_pkg::KIND_FREE_RUN)) ? in_total
					                                                    : bpa_pkg::CNT_W'(1);
					p_q         <= '0;
					look_used_q <= 1'b0;
					res_q       <= '0;
					ok_q        <= 1'b0;
				end
			end
			bpa_pkg::ST_FPAGE: begin
				below_q <= addr_q < base_q;
				page_q  <= PGW'((addr_q - base_q) >> PSH);
			end
			bpa_pkg::ST_FRANGE: begin
				lo_q  <= page_q[CW-1:0];
				hi_q  <= free_hi;
				p_q   <= page_q[CW-1:0];
				set_q <= 1'b0;
			end
			bpa_pkg::ST_ALOAD: begin
				// reserved pages and pages past the count show as used
				rmask_q <= bpa_pkg::low_mask(span_clamp(resv_w, wbase));
				cmask_q <= ~bpa_pkg::low_mask(span_clamp(count_w, wbase));
			end
			bpa_pkg::ST_AFREE: begin
				if (ffs_found) begin
					start_q     <= hit_g;
					p_q         <= hit_g;
					look_used_q <= 1'b1;
				end else if (!past_end) begin
					p_q <= nb;
				end
			end
			bpa_pkg::ST_AUSED: begin
				if ((ffs_found && run_hit_ok) || (!ffs_found && run_end_ok)) begin
					lo_q  <= start_q;
					hi_q  <= start_q + need_w;
					p_q   <= start_q;
					set_q <= 1'b1;
					res_q <= base_q + (AW'(start_q) << PSH);
					ok_q  <= 1'b1;
				end else if (ffs_found) begin
					p_q         <= hit_g;
					look_used_q <= 1'b0;
				end else if (!past_end) begin
					p_q <= nb;
				end
			end
			bpa_pkg::ST_MREAD: begin
				mmask_q <= bpa_pkg::low_mask(span_clamp(hi_q, wbase)) &
				           ~bpa_pkg::low_mask(span_clamp(lo_q, wbase));
			end
			bpa_pkg::ST_MWRITE: begin
				p_q <= nb;
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;
	assign m_axis_tuser  = ook_q;

endmodule

// File: src/bpa_checker.sv
// Port-level checks for the bitmap page allocator, bound to the top level.
`include "bitmap_page_allocator_core_defines.svh"

module bpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// a stalled result beat holds
	`BPA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

	// failures and frees carry address zero
	`BPA_ASSERT_SAME(a_fail_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 48'd0, "non-ok result with non-zero address")

	// one request at a time: busy straight after an accepted beat
	`BPA_ASSERT_NEXT(a_busy_after, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready again right after accept")

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (.*);
